// ===== rtl/core/assert_macros.svh =====
// assertion macros included by servo_angle_command_pwm.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is low
`define SACP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sacp assertion failed");

// next-cycle implication, disabled while reset is low
`define SACP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sacp assertion failed");

`else

`define SACP_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define SACP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/sacp_pkg.sv =====
`default_nettype none

package sacp_pkg;

    // input item operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_PWM    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_PERIOD_TICKS = 2'd0;
    localparam logic [1:0] CFG_MIN_PULSE    = 2'd1;
    localparam logic [1:0] CFG_PULSE_SPAN   = 2'd2;

    // ascii codes
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // angle and accumulator limits
    localparam logic [7:0] MAX_ANGLE = 8'd180;
    localparam logic [7:0] ACC_MAX   = 8'd255;

    // register reset values
    localparam logic [15:0] PERIOD_TICKS_RST = 16'd39999;
    localparam logic [15:0] MIN_PULSE_RST    = 16'd2000;
    localparam logic [15:0] PULSE_SPAN_RST   = 16'd2000;
    localparam logic [15:0] NEUTRAL_COMPARE  = 16'd3000;

    // divide by 180 as multiply by ceil(2^32 / 180), exact for 24-bit dividends
    localparam int          SCALE_SHIFT = 32;
    localparam int          SCALED_W    = 41;
    localparam logic [24:0] SCALE_MUL   = 25'd23860930;
    localparam logic [SCALED_W-1:0] SPAN_SCALED_RST =
        SCALED_W'(PULSE_SPAN_RST) * SCALED_W'(SCALE_MUL);

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  angle;
        logic [15:0] compare_value;
        logic        pwm_out;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/servo_angle_command_pwm.sv =====
// output: an accepted item's result is registered and appears in the output register in the next cycle
// throughput: one item per cycle, ticks and bytes alike, while m_ready drains the output register
// pulse width math: span is pre-scaled by 1/180 at config write, one 8 x 41 multiply per item
// reset: synchronous active-low aresetn restores config defaults, neutral compare 3000,
// clears the parse state, the period counter and the output valid
`default_nettype none

`include "assert_macros.svh"

module servo_angle_command_pwm #(
    parameter int COUNTER_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire sacp_pkg::in_item_t  s_data,

    output logic                     m_valid,
    input  wire logic                m_ready,
    output sacp_pkg::out_item_t      m_data,

    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_data
);

    import sacp_pkg::*;

    localparam int CMP_W = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
    localparam int PROD_W = SCALED_W + 8;

    // configuration registers
    logic [15:0]         period_ticks_reg;
    logic [15:0]         min_pulse_reg;
    logic [SCALED_W-1:0] span_scaled_reg;

    // block state
    logic [7:0]              acc_reg, acc_next;
    logic                    seen_reg, seen_next;
    logic [15:0]             pending_reg, pending_next;
    logic [15:0]             active_reg, active_next;
    logic [COUNTER_BITS-1:0] count_reg, count_next;

    // output register
    logic      m_valid_reg;
    out_item_t m_data_reg;

    logic      s_xfer;
    logic      res_valid;
    out_item_t res;

    logic [11:0]             acc_dec;
    logic                    is_digit;
    logic                    is_eol;
    logic [PROD_W-1:0]       prod;
    logic [16:0]             cmp_sum;
    logic [15:0]             cmp_sat;
    logic [CMP_W-1:0]        period_ext;
    logic [COUNTER_BITS-1:0] top;
    logic [15:0]             cmp_now;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_xfer    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // byte decode and arithmetic
    assign is_digit = (s_data.rx_byte >= CHAR_ZERO) && (s_data.rx_byte <= CHAR_NINE);
    assign is_eol   = (s_data.rx_byte == CHAR_CR) || (s_data.rx_byte == CHAR_LF);
    assign acc_dec  = 12'({acc_reg, 3'b000}) + 12'({acc_reg, 1'b0})
                    + 12'(s_data.rx_byte[3:0]);
    assign prod     = PROD_W'(acc_reg) * PROD_W'(span_scaled_reg);
    assign cmp_sum  = 17'(min_pulse_reg) + 17'(prod[SCALE_SHIFT +: 16]);
    assign cmp_sat  = cmp_sum[16] ? 16'hffff : cmp_sum[15:0];

    // pwm period terms
    assign period_ext = CMP_W'(period_ticks_reg);
    assign top        = period_ext[COUNTER_BITS-1:0];
    assign cmp_now    = (count_reg == '0) ? pending_reg : active_reg;

    // next state and result for one item
    always_comb begin
        acc_next     = acc_reg;
        seen_next    = seen_reg;
        pending_next = pending_reg;
        active_next  = active_reg;
        count_next   = count_reg;
        res_valid    = 1'b0;
        res          = '0;
        if (s_data.op == OP_TICK) begin
            active_next  = cmp_now;
            res_valid    = 1'b1;
            res.kind     = KIND_PWM;
            res.pwm_out  = CMP_W'(count_reg) < CMP_W'(cmp_now);
            if (count_reg >= top) begin
                count_next = '0;
            end else begin
                count_next = count_reg + COUNTER_BITS'(1);
            end
        end else if (is_digit) begin
            acc_next  = (acc_dec > 12'(ACC_MAX)) ? ACC_MAX : acc_dec[7:0];
            seen_next = 1'b1;
        end else if (is_eol && !seen_reg) begin
            // line end with no digits is dropped
            res_valid = 1'b0;
        end else if (is_eol && (acc_reg <= MAX_ANGLE)) begin
            acc_next          = '0;
            seen_next         = 1'b0;
            pending_next      = cmp_sat;
            res_valid         = 1'b1;
            res.kind          = KIND_ACCEPT;
            res.angle         = acc_reg;
            res.compare_value = cmp_sat;
        end else begin
            acc_next  = '0;
            seen_next = 1'b0;
            res_valid = 1'b1;
            res.kind  = KIND_REJECT;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_ticks_reg <= PERIOD_TICKS_RST;
            min_pulse_reg    <= MIN_PULSE_RST;
            span_scaled_reg  <= SPAN_SCALED_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PERIOD_TICKS: period_ticks_reg <= cfg_data;
                CFG_MIN_PULSE:    min_pulse_reg    <= cfg_data;
                CFG_PULSE_SPAN:   span_scaled_reg  <= SCALED_W'(cfg_data)
                                                    * SCALED_W'(SCALE_MUL);
                default:          ;
            endcase
        end
    end

    // block state update on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            seen_reg    <= 1'b0;
            pending_reg <= NEUTRAL_COMPARE;
            active_reg  <= NEUTRAL_COMPARE;
            count_reg   <= '0;
        end else if (s_xfer) begin
            acc_reg     <= acc_next;
            seen_reg    <= seen_next;
            pending_reg <= pending_next;
            active_reg  <= active_next;
            count_reg   <= count_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_xfer && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && res_valid) begin
            m_data_reg <= res;
        end
    end

    // a tick transfer always leaves a pwm result in the output register
    `SACP_ASSERT_NEXT(a_tick_result, aclk, aresetn, s_xfer && (s_data.op == OP_TICK), m_valid && (m_data.kind == KIND_PWM))

    // pending compare only moves on a byte transfer
    `SACP_ASSERT_NOW(a_pending_src, aclk, aresetn, $past(aresetn) && (pending_reg != $past(pending_reg)), $past(s_xfer) && ($past(s_data.op) == OP_BYTE))

    // active compare only moves on a tick at the period start
    `SACP_ASSERT_NOW(a_active_src, aclk, aresetn, $past(aresetn) && (active_reg != $past(active_reg)), $past(s_xfer) && ($past(s_data.op) == OP_TICK) && ($past(count_reg) == '0))

endmodule

`default_nettype wire
